### src/lvc_pkg.sv
// Package for the LFU value cache: sizes, word types, kind codes and the
// saturating count step. Used by lfu_value_cache; no dependencies.

package lvc_pkg;

    localparam int ENTRIES     = 32;
    localparam int TAG_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 31;
    localparam int LIMIT_BITS  = 6;
    localparam int KIND_BITS   = 2;
    localparam int IDX_BITS    = $clog2(ENTRIES);
    localparam int OCC_BITS    = $clog2(ENTRIES + 1);
    localparam int CMP_BITS    = (LIMIT_BITS > OCC_BITS) ? LIMIT_BITS : OCC_BITS;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(25);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE   = COUNT_BITS'(1);
    localparam logic [IDX_BITS-1:0]   LAST_IDX    = IDX_BITS'(ENTRIES - 1);
    localparam logic [CMP_BITS-1:0]   ENTRIES_CMP = CMP_BITS'(ENTRIES);
    localparam logic [CMP_BITS-1:0]   ONE_CMP     = CMP_BITS'(1);

    localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_FILL   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [TAG_BITS-1:0]   key_tag;
        logic [VALUE_BITS-1:0] fill_value;
    } t_in_word;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
    } t_out_word;

    typedef struct packed {
        logic [TAG_BITS-1:0]   tag;
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
        return (c == COUNT_MAX) ? c : c + COUNT_ONE;
    endfunction

endpackage

### src/lvc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module lvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/lfu_value_cache.sv
// LFU value cache top level: scan sequencer, valid bits and result register.
// Depends on lvc_pkg and lvc_ram (tag, value and count store).
//
// Usage:
//  - Input channel i_in_valid / o_in_stall carries one word: kind, key_tag,
//    fill_value. Output channel o_out_valid / i_out_stall returns hit,
//    read_value and evicted, one result word per input word, in order.
//  - i_cfg_we / i_cfg_data write max_entries; write it only when idle.
//  - One item is in flight at a time. A lookup or fill walks every slot of
//    the entry RAM, one read a cycle, matching the tag, tracking the lowest
//    count and the first free slot, then writes back at most once before
//    the result. A clear or an unused kind skips the scan and goes straight
//    to the result.
//  - The result register lets a new word be accepted while the previous
//    result is still held; when the receiver stalls, the finished result of
//    the next item waits inside until the register frees up.
//  - Reset clears the valid bits and occupancy at once (no clearing pass),
//    sets max_entries to 25 and empties the result register.

module lfu_value_cache (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lvc_pkg::LIMIT_BITS-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  lvc_pkg::t_in_word                i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output lvc_pkg::t_out_word               o_out_word
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_WRITE  = 4'b0100,
        ST_RESULT = 4'b1000
    } t_state;

    localparam int IW = lvc_pkg::IDX_BITS;

    t_state                              r_state, n_state;
    lvc_pkg::t_in_word                   r_item, n_item;
    logic [IW:0]                         r_addr, n_addr;
    logic                                r_chk, n_chk;
    logic [IW-1:0]                       r_chk_idx, n_chk_idx;
    logic                                r_found, n_found;
    logic [IW-1:0]                       r_found_idx, n_found_idx;
    lvc_pkg::t_entry                     r_found_ent, n_found_ent;
    logic                                r_min_any, n_min_any;
    logic [IW-1:0]                       r_min_idx, n_min_idx;
    logic [lvc_pkg::COUNT_BITS-1:0]      r_min_cnt, n_min_cnt;
    logic                                r_free_any, n_free_any;
    logic [IW-1:0]                       r_free_idx, n_free_idx;
    logic [lvc_pkg::ENTRIES-1:0]         r_valid, n_valid;
    logic [lvc_pkg::OCC_BITS-1:0]        r_occ, n_occ;
    logic [lvc_pkg::LIMIT_BITS-1:0]      r_max_entries, n_max_entries;
    lvc_pkg::t_out_word                  r_res, n_res;
    logic                                r_out_valid, n_out_valid;
    lvc_pkg::t_out_word                  r_out_word, n_out_word;

    logic                                ram_we;
    logic [IW-1:0]                       ram_waddr;
    lvc_pkg::t_entry                     ram_wdata;
    logic [IW-1:0]                       ram_raddr;
    lvc_pkg::t_entry                     ram_rdata;

    logic [lvc_pkg::CMP_BITS-1:0]        lim_raw;
    logic [lvc_pkg::CMP_BITS-1:0]        lim;
    logic                                full;
    logic                                in_acc;

    lvc_ram #(
        .WIDTH ($bits(lvc_pkg::t_entry)),
        .DEPTH (lvc_pkg::ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // limit of 0 acts as 1, above ENTRIES acts as ENTRIES
    always_comb begin
        lim_raw = lvc_pkg::CMP_BITS'(r_max_entries);
        if (lim_raw == '0) begin
            lim = lvc_pkg::ONE_CMP;
        end else if (lim_raw > lvc_pkg::ENTRIES_CMP) begin
            lim = lvc_pkg::ENTRIES_CMP;
        end else begin
            lim = lim_raw;
        end
        full = lvc_pkg::CMP_BITS'(r_occ) >= lim;
    end

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        n_addr        = r_addr;
        n_chk         = 1'b0;
        n_chk_idx     = r_chk_idx;
        n_found       = r_found;
        n_found_idx   = r_found_idx;
        n_found_ent   = r_found_ent;
        n_min_any     = r_min_any;
        n_min_idx     = r_min_idx;
        n_min_cnt     = r_min_cnt;
        n_free_any    = r_free_any;
        n_free_idx    = r_free_idx;
        n_valid       = r_valid;
        n_occ         = r_occ;
        n_max_entries = r_max_entries;
        n_res         = r_res;
        n_out_valid   = r_out_valid;
        n_out_word    = r_out_word;
        ram_we        = 1'b0;
        ram_waddr     = r_found_idx;
        ram_wdata     = r_found_ent;
        ram_raddr     = r_addr[IW-1:0];

        if (i_cfg_we) begin
            n_max_entries = i_cfg_data;
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_item     = i_in_word;
                    n_addr     = '0;
                    n_found    = 1'b0;
                    n_min_any  = 1'b0;
                    n_free_any = 1'b0;
                    n_res      = '0;
                    case (i_in_word.kind)
                        lvc_pkg::KIND_LOOKUP, lvc_pkg::KIND_FILL: begin
                            n_state = ST_SCAN;
                        end
                        lvc_pkg::KIND_CLEAR: begin
                            n_valid = '0;
                            n_occ   = '0;
                            n_state = ST_RESULT;
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // issue one read a cycle; data comes back the cycle after
                if (!r_addr[IW]) begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_addr[IW-1:0];
                    n_addr    = r_addr + (IW + 1)'(1);
                end
                if (r_chk) begin
                    if (r_valid[r_chk_idx]) begin
                        if (!r_found && ram_rdata.tag == r_item.key_tag) begin
                            n_found     = 1'b1;
                            n_found_idx = r_chk_idx;
                            n_found_ent = ram_rdata;
                        end
                        // strict less keeps the lowest slot on a tie
                        if (!r_min_any || ram_rdata.count < r_min_cnt) begin
                            n_min_any = 1'b1;
                            n_min_idx = r_chk_idx;
                            n_min_cnt = ram_rdata.count;
                        end
                    end else if (!r_free_any) begin
                        n_free_any = 1'b1;
                        n_free_idx = r_chk_idx;
                    end
                    if (r_chk_idx == lvc_pkg::LAST_IDX) begin
                        n_state = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                n_state = ST_RESULT;
                if (r_found) begin
                    ram_we          = 1'b1;
                    ram_waddr       = r_found_idx;
                    ram_wdata       = r_found_ent;
                    ram_wdata.count = lvc_pkg::count_up(r_found_ent.count);
                    n_res.hit       = 1'b1;
                    if (r_item.kind == lvc_pkg::KIND_LOOKUP) begin
                        n_res.read_value = r_found_ent.value;
                    end
                end else if (r_item.kind == lvc_pkg::KIND_FILL) begin
                    ram_wdata.tag   = r_item.key_tag;
                    ram_wdata.value = r_item.fill_value;
                    if (full) begin
                        ram_we          = r_min_any;
                        ram_waddr       = r_min_idx;
                        ram_wdata.count = lvc_pkg::count_up(r_min_cnt);
                        n_res.evicted   = r_min_any;
                    end else begin
                        ram_we              = r_free_any;
                        ram_waddr           = r_free_idx;
                        ram_wdata.count     = lvc_pkg::COUNT_ONE;
                        n_valid[r_free_idx] = r_free_any;
                        n_occ               = r_occ + lvc_pkg::OCC_BITS'(r_free_any);
                    end
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_chk         <= 1'b0;
            r_valid       <= '0;
            r_occ         <= '0;
            r_max_entries <= lvc_pkg::LIMIT_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_chk         <= n_chk;
            r_valid       <= n_valid;
            r_occ         <= n_occ;
            r_max_entries <= n_max_entries;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_addr      <= n_addr;
        r_chk_idx   <= n_chk_idx;
        r_found     <= n_found;
        r_found_idx <= n_found_idx;
        r_found_ent <= n_found_ent;
        r_min_any   <= n_min_any;
        r_min_idx   <= n_min_idx;
        r_min_cnt   <= n_min_cnt;
        r_free_any  <= n_free_any;
        r_free_idx  <= n_free_idx;
        r_res       <= n_res;
        r_out_word  <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // occupancy tracks the valid bits exactly
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lvc_pkg::OCC_BITS'($countones(r_valid)) == r_occ)
        else $error("occupancy out of step with valid bits");

    // a fill that inserts below the limit always found a free slot
    a_free_slot_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && r_item.kind == lvc_pkg::KIND_FILL && !r_found && !full)
        |-> r_free_any)
        else $error("no free slot for insert below limit");

    // a fill that evicts always found a victim
    a_victim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && r_item.kind == lvc_pkg::KIND_FILL && !r_found && full)
        |-> r_min_any)
        else $error("no victim for eviction");

    // a result word is only loaded on leaving the result state
    a_out_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_state == ST_RESULT) && $past(i_rst_n)) |-> (r_out_valid == 1'b0
        || $past(r_out_valid && i_out_stall)))
        else $error("result word appeared outside the result state");

endmodule
